@@ rtl/serial_frame_builder_top_defines.svh @@
// Assertion helpers shared by the frame builder RTL.
`ifndef SERIAL_FRAME_BUILDER_TOP_DEFINES_SVH
`define SERIAL_FRAME_BUILDER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sfb_pkg.sv @@
package sfb_pkg;

    localparam int LEN_W = 4;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_CRC   = 2'd1,
        MODE_SUM8  = 2'd2,
        MODE_SUM16 = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_HEADER_BYTES  = 3'd0,
        CFG_HEADER_LEN    = 3'd1,
        CFG_TRAILER_BYTES = 3'd2,
        CFG_TRAILER_LEN   = 3'd3,
        CFG_CHECK_MODE    = 3'd4
    } t_cfg_idx;

    localparam logic [63:0]      RST_HEADER_BYTES  = 64'h0000_0000_00AA_5500;
    localparam logic [LEN_W-1:0] RST_HEADER_LEN    = 4'd3;
    localparam logic [63:0]      RST_TRAILER_BYTES = 64'h0000_0000_00DD_CCBB;
    localparam logic [LEN_W-1:0] RST_TRAILER_LEN   = 4'd3;
    localparam logic [15:0]      CRC_POLY          = 16'h1021;

    typedef struct packed {
        logic [63:0]      header_bytes;
        logic [LEN_W-1:0] header_len;
        logic [63:0]      trailer_bytes;
        logic [LEN_W-1:0] trailer_len;
        t_mode            check_mode;
    } t_cfg;

    // One classified item handed from front to back.
    typedef struct packed {
        logic        first;
        logic [15:0] len;
        logic        has_byte;
        logic [7:0]  data;
        logic        last;
        logic        shrt;
    } t_cmd;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n,
                                                   input logic [LEN_W-1:0] lim);
        return (n > lim) ? lim : n;
    endfunction

    function automatic logic [15:0] check_next(input logic [15:0] acc,
                                               input logic [7:0] b,
                                               input t_mode mode);
        logic [15:0] a;
        logic [7:0]  d;
        a = acc;
        d = b;
        case (mode)
            MODE_CRC: begin
                for (int i = 0; i < 8; i++) begin
                    if (d[7] ^ a[15]) begin
                        a = {a[14:0], 1'b0} ^ CRC_POLY;
                    end else begin
                        a = {a[14:0], 1'b0};
                    end
                    d = {d[6:0], 1'b0};
                end
            end
            MODE_SUM8, MODE_SUM16: a = acc + {8'd0, b};
            default: a = acc;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/serial_frame_builder_top.sv @@
// Byte frame builder. Each accepted item carries one payload byte (or none), the
// declared frame length (used on a frame's first item) and a last mark. Output is
// header, 16-bit clipped length low byte first, payload, check (none, CRC-16 poly
// 0x1021 init 0, 8-bit sum or 16-bit sum, high byte first) and trailer. Items are
// taken one per cycle while the queue is not full into a QUEUE_DEPTH-entry
// command queue; the byte sequencer behind it sends one frame byte per cycle
// unless the output stalls. Sustained rate is set by the single-byte output
// register. On an idle block an item passes the queue and the command register
// before its first byte reaches the output register. Configuration is to be
// written by the user only while the block is idle; the block does not enforce it.
module serial_frame_builder_top
    import sfb_pkg::*;
#(
    parameter int MAX_HEAD_LEN = 8,
    parameter int MAX_FRAME    = 1024,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_byte_valid,
    input  logic [15:0] i_frame_length,
    input  logic        i_end_of_frame,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_done,
    output logic        o_short_frame,
    output logic        o_out_valid,
    input  logic        i_out_stall
);

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_bytes  <= RST_HEADER_BYTES;
            r_cfg.header_len    <= RST_HEADER_LEN;
            r_cfg.trailer_bytes <= RST_TRAILER_BYTES;
            r_cfg.trailer_len   <= RST_TRAILER_LEN;
            r_cfg.check_mode    <= MODE_CRC;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HEADER_BYTES:  r_cfg.header_bytes  <= i_cfg_data;
                CFG_HEADER_LEN:    r_cfg.header_len    <= i_cfg_data[LEN_W-1:0];
                CFG_TRAILER_BYTES: r_cfg.trailer_bytes <= i_cfg_data;
                CFG_TRAILER_LEN:   r_cfg.trailer_len   <= i_cfg_data[LEN_W-1:0];
                CFG_CHECK_MODE:    r_cfg.check_mode    <= t_mode'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    assign o_in_stall = full;

    sfb_front #(
        .MAX_HEAD_LEN (MAX_HEAD_LEN),
        .MAX_FRAME    (MAX_FRAME)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_payload_byte (i_payload_byte),
        .i_byte_valid   (i_byte_valid),
        .i_frame_length (i_frame_length),
        .i_end_of_frame (i_end_of_frame),
        .i_in_valid     (i_in_valid),
        .i_full         (full),
        .i_cfg          (r_cfg),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    sfb_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head_cmd)
    );

    sfb_back #(
        .MAX_HEAD_LEN (MAX_HEAD_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (head_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_out_byte    (o_out_byte),
        .o_frame_done  (o_frame_done),
        .o_short_frame (o_short_frame),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall)
    );

endmodule

@@ rtl/sfb_front.sv @@
module sfb_front
    import sfb_pkg::*;
#(
    parameter int MAX_HEAD_LEN = 8,
    parameter int MAX_FRAME    = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_byte_valid,
    input  logic [15:0] i_frame_length,
    input  logic        i_end_of_frame,
    input  logic        i_in_valid,
    input  logic        i_full,
    input  t_cfg        i_cfg,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [16:0] FRAME_SZ = 17'(MAX_FRAME);

    logic        r_in_frame;
    logic [15:0] r_taken;
    logic [15:0] r_held;

    logic [LEN_W-1:0] hl;
    logic [LEN_W-1:0] tl;
    logic [16:0]      room;
    logic [15:0]      clip_len;
    logic [15:0]      held;
    logic [15:0]      taken;
    logic             take;
    logic [15:0]      taken_nxt;
    logic             accept;

    always_comb begin
        hl        = clamp_len(i_cfg.header_len, LEN_W'(MAX_HEAD_LEN));
        tl        = clamp_len(i_cfg.trailer_len, LEN_W'(MAX_HEAD_LEN));
        room      = FRAME_SZ - 17'(hl) - 17'(tl) - 17'd2;
        clip_len  = ({1'b0, i_frame_length} > room) ? room[15:0] : i_frame_length;
        held      = r_in_frame ? r_held : clip_len;
        taken     = r_in_frame ? r_taken : 16'd0;
        take      = i_byte_valid && (taken < held);
        taken_nxt = taken + {15'd0, take};
        accept    = i_in_valid && !i_full;
    end

    assign o_push       = accept;
    assign o_cmd.first    = !r_in_frame;
    assign o_cmd.len      = held;
    assign o_cmd.has_byte = take;
    assign o_cmd.data     = i_payload_byte;
    assign o_cmd.last     = i_end_of_frame;
    assign o_cmd.shrt     = taken_nxt < held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_taken    <= 16'd0;
            r_held     <= 16'd0;
        end else if (accept) begin
            if (i_end_of_frame) begin
                r_in_frame <= 1'b0;
                r_taken    <= 16'd0;
                r_held     <= 16'd0;
            end else begin
                r_in_frame <= 1'b1;
                r_taken    <= taken_nxt;
                r_held     <= held;
            end
        end
    end

endmodule

@@ rtl/sfb_cmd_fifo.sv @@
`include "serial_frame_builder_top_defines.svh"

module sfb_cmd_fifo
    import sfb_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    `SFB_ASSERT_NOW(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "queue overrun")
    `SFB_ASSERT_NOW(a_fifo_pop, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")

endmodule

@@ rtl/sfb_back.sv @@
`include "serial_frame_builder_top_defines.svh"

module sfb_back
    import sfb_pkg::*;
#(
    parameter int MAX_HEAD_LEN = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic [7:0] o_out_byte,
    output logic       o_frame_done,
    output logic       o_short_frame,
    output logic       o_out_valid,
    input  logic       i_out_stall
);

    localparam int CW = (MAX_HEAD_LEN > 1) ? $clog2(MAX_HEAD_LEN) : 1;

    typedef enum logic [2:0] {
        P_HDR    = 3'd0,
        P_LEN_LO = 3'd1,
        P_LEN_HI = 3'd2,
        P_PAY    = 3'd3,
        P_CHK_HI = 3'd4,
        P_CHK_LO = 3'd5,
        P_TRL    = 3'd6
    } t_phase;

    logic          r_busy;
    t_cmd          r_cmd;
    t_phase        r_phase;
    logic [CW-1:0] r_cnt;
    logic [15:0]   r_acc;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_done;
    logic          r_out_short;

    logic          n_busy;
    t_cmd          n_cmd;
    t_phase        n_phase;
    logic [CW-1:0] n_cnt;
    logic [15:0]   n_acc;
    logic          n_out_valid;
    logic [7:0]    n_out_byte;
    logic          n_out_done;
    logic          n_out_short;

    logic [LEN_W-1:0] hl;
    logic [LEN_W-1:0] tl;
    logic [6:0]       en_cur;
    logic [6:0]       en_rest;
    logic [6:0]       en_new;
    logic             out_adv;
    logic             emit;
    logic             ph_end;
    logic             cmd_end;
    logic             load;
    logic             tracked;
    logic [7:0]       byte_sel;

    function automatic logic [6:0] phase_en(input t_cmd c, input t_mode m,
                                            input logic [LEN_W-1:0] h,
                                            input logic [LEN_W-1:0] t);
        logic [6:0] e;
        e           = '0;
        e[P_HDR]    = c.first && (h != '0);
        e[P_LEN_LO] = c.first;
        e[P_LEN_HI] = c.first;
        e[P_PAY]    = c.has_byte;
        e[P_CHK_HI] = c.last && ((m == MODE_CRC) || (m == MODE_SUM16));
        e[P_CHK_LO] = c.last && (m != MODE_NONE);
        e[P_TRL]    = c.last && (t != '0);
        return e;
    endfunction

    function automatic t_phase lowest(input logic [6:0] e);
        t_phase p;
        p = P_HDR;
        for (int i = 6; i >= 0; i--) begin
            if (e[i]) begin
                p = t_phase'(3'(i));
            end
        end
        return p;
    endfunction

    always_comb begin
        hl      = clamp_len(i_cfg.header_len, LEN_W'(MAX_HEAD_LEN));
        tl      = clamp_len(i_cfg.trailer_len, LEN_W'(MAX_HEAD_LEN));
        en_cur  = phase_en(r_cmd, i_cfg.check_mode, hl, tl);
        en_new  = phase_en(i_cmd, i_cfg.check_mode, hl, tl);
        en_rest = en_cur & ~((7'd2 << r_phase) - 7'd1);
        out_adv = !r_out_valid || !i_out_stall;
        emit    = r_busy && out_adv;

        case (r_phase)
            P_HDR:   ph_end = ((LEN_W'(r_cnt) + 1'b1) == hl);
            P_TRL:   ph_end = ((LEN_W'(r_cnt) + 1'b1) == tl);
            default: ph_end = 1'b1;
        endcase

        cmd_end = emit && ph_end && (en_rest == '0);
        load    = (!r_busy || cmd_end) && i_cmd_valid;

        tracked  = 1'b0;
        case (r_phase)
            P_HDR:    byte_sel = 8'(i_cfg.header_bytes >> {r_cnt, 3'b000});
            P_LEN_LO: begin byte_sel = r_cmd.len[7:0];  tracked = 1'b1; end
            P_LEN_HI: begin byte_sel = r_cmd.len[15:8]; tracked = 1'b1; end
            P_PAY:    begin byte_sel = r_cmd.data;      tracked = 1'b1; end
            P_CHK_HI: byte_sel = r_acc[15:8];
            P_CHK_LO: byte_sel = r_acc[7:0];
            P_TRL:    byte_sel = 8'(i_cfg.trailer_bytes >> {r_cnt, 3'b000});
            default:  byte_sel = 8'd0;
        endcase

        // output register
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_done  = r_out_done;
        n_out_short = r_out_short;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = byte_sel;
            n_out_done  = cmd_end && r_cmd.last;
            n_out_short = cmd_end && r_cmd.last && r_cmd.shrt;
        end else if (out_adv) begin
            n_out_valid = 1'b0;
        end

        // running check; cleared once a frame closes
        n_acc = r_acc;
        if (emit && tracked) begin
            n_acc = check_next(r_acc, byte_sel, i_cfg.check_mode);
        end
        if (cmd_end && r_cmd.last) begin
            n_acc = 16'd0;
        end
        if (load && (en_new == '0) && i_cmd.last) begin
            n_acc = 16'd0;
        end

        n_busy  = r_busy;
        n_cmd   = r_cmd;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        if (load) begin
            n_busy  = (en_new != '0);
            n_cmd   = i_cmd;
            n_phase = lowest(en_new);
            n_cnt   = '0;
        end else if (cmd_end) begin
            n_busy = 1'b0;
        end else if (emit && !ph_end) begin
            n_cnt = r_cnt + 1'b1;
        end else if (emit) begin
            n_phase = lowest(en_rest);
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= P_HDR;
            r_cnt       <= '0;
            r_acc       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
        r_cmd       <= n_cmd;
        r_out_byte  <= n_out_byte;
        r_out_done  <= n_out_done;
        r_out_short <= n_out_short;
    end

    assign o_pop         = load;
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_frame_done  = r_out_done;
    assign o_short_frame = r_out_short;

    `SFB_ASSERT_NOW(a_short_done, i_clk, i_rst_n, r_out_valid && r_out_short, r_out_done, "short flag without frame end")
    `SFB_ASSERT_NOW(a_tail_last, i_clk, i_rst_n, r_busy && (r_phase == P_CHK_HI || r_phase == P_CHK_LO || r_phase == P_TRL), r_cmd.last, "check or trailer on a non-final item")
    `SFB_ASSERT_NEXT(a_acc_clear, i_clk, i_rst_n, cmd_end && r_cmd.last, r_acc == 16'd0, "check not cleared after frame")

endmodule

@@ sim/serial_frame_builder_top_tb.sv @@
`timescale 1ns / 1ps

module serial_frame_builder_top_tb
    import sfb_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int RANDOM_ITEMS   = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       done;
        logic       shrt;
    } t_frame_beat;

    // Predicts the byte stream of the builder and holds the bytes still owed.
    class frame_scoreboard;
        localparam int HEAD_CAP  = 8;
        localparam int FRAME_CAP = 1024;

        logic [63:0] hdr_bytes;
        logic [3:0]  hdr_len;
        logic [63:0] trl_bytes;
        logic [3:0]  trl_len;
        t_mode       mode;
        bit          in_frame;
        logic [15:0] acc;
        logic [15:0] taken;
        logic [15:0] held;
        t_frame_beat step_beats[$];
        t_frame_beat expected_beats[$];

        function new();
            hdr_bytes = RST_HEADER_BYTES;
            hdr_len   = RST_HEADER_LEN;
            trl_bytes = RST_TRAILER_BYTES;
            trl_len   = RST_TRAILER_LEN;
            mode      = MODE_CRC;
            in_frame  = 1'b0;
            acc       = '0;
            taken     = '0;
            held      = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [63:0] val);
            case (idx)
                CFG_HEADER_BYTES:  hdr_bytes = val;
                CFG_HEADER_LEN:    hdr_len = val[3:0];
                CFG_TRAILER_BYTES: trl_bytes = val;
                CFG_TRAILER_LEN:   trl_len = val[3:0];
                CFG_CHECK_MODE:    mode = t_mode'(val[1:0]);
                default: ;
            endcase
        endfunction

        function int clamp_count(logic [3:0] n);
            return (n > HEAD_CAP) ? HEAD_CAP : int'(n);
        endfunction

        function void fold_byte(logic [7:0] b);
            logic [15:0] a;
            logic [7:0]  d;
            logic        fb;
            a = acc;
            d = b;
            case (mode)
                MODE_CRC: begin
                    repeat (8) begin
                        fb = d[7] ^ a[15];
                        a  = {a[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
                        d  = {d[6:0], 1'b0};
                    end
                end
                MODE_SUM8, MODE_SUM16: a = a + {8'h00, b};
                default: ;
            endcase
            acc = a;
        endfunction

        function void push_beat(logic [7:0] b);
            t_frame_beat nb;
            nb      = '0;
            nb.data = b;
            step_beats.push_back(nb);
        endfunction

        // length and payload bytes feed the check
        function void push_counted(logic [7:0] b);
            push_beat(b);
            fold_byte(b);
        endfunction

        function void note_item(logic [7:0] pb, logic bv, logic [15:0] fl, logic eof);
            int          hl;
            int          tl;
            int          room;
            int          k;
            logic [15:0] len;
            logic        shrt;
            t_frame_beat tail;
            step_beats.delete();
            if (!in_frame) begin
                hl   = clamp_count(hdr_len);
                tl   = clamp_count(trl_len);
                room = FRAME_CAP - hl - tl - 2;
                len  = (int'(fl) > room) ? 16'(room) : fl;
                for (k = 0; k < hl; k++) begin
                    push_beat(hdr_bytes[8*k +: 8]);
                end
                in_frame = 1'b1;
                acc      = '0;
                taken    = '0;
                held     = len;
                push_counted(len[7:0]);
                push_counted(len[15:8]);
            end
            if (bv && taken < held) begin
                push_counted(pb);
                taken = taken + 16'd1;
            end
            if (eof) begin
                shrt = taken < held;
                case (mode)
                    MODE_CRC, MODE_SUM16: begin
                        push_beat(acc[15:8]);
                        push_beat(acc[7:0]);
                    end
                    MODE_SUM8: push_beat(acc[7:0]);
                    default: ;
                endcase
                tl = clamp_count(trl_len);
                for (k = 0; k < tl; k++) begin
                    push_beat(trl_bytes[8*k +: 8]);
                end
                // an ending item that emits nothing leaves no done flag
                if (step_beats.size() > 0) begin
                    tail      = step_beats.pop_back();
                    tail.done = 1'b1;
                    tail.shrt = shrt;
                    step_beats.push_back(tail);
                end
                in_frame = 1'b0;
                acc      = '0;
                taken    = '0;
                held     = '0;
            end
            for (k = 0; k < step_beats.size(); k++) begin
                expected_beats.push_back(step_beats[k]);
            end
        endfunction

        function bit check_beat(t_frame_beat got, output string why);
            t_frame_beat want;
            why = "";
            if (expected_beats.size() == 0) begin
                why = $sformatf("byte %02h done %0b short %0b with nothing expected",
                                got.data, got.done, got.shrt);
                return 1'b0;
            end
            want = expected_beats.pop_front();
            if (got.data !== want.data || got.done !== want.done ||
                got.shrt !== want.shrt) begin
                why = {$sformatf("got byte %02h done %0b short %0b, ",
                                 got.data, got.done, got.shrt),
                       $sformatf("want byte %02h done %0b short %0b",
                                 want.data, want.done, want.shrt)};
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic [7:0]  i_payload_byte;
    logic        i_byte_valid;
    logic [15:0] i_frame_length;
    logic        i_end_of_frame;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  o_out_byte;
    logic        o_frame_done;
    logic        o_short_frame;
    logic        o_out_valid;
    logic        i_out_stall;

    frame_scoreboard sb;
    int          mismatches = 0;
    int          items_sent = 0;
    bit          tx_eager = 1'b0;
    bit          rx_eager = 1'b0;
    bit          in_take = 1'b0;
    bit          out_take = 1'b0;
    t_frame_beat seen_beat;

    serial_frame_builder_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_payload_byte (i_payload_byte),
        .i_byte_valid   (i_byte_valid),
        .i_frame_length (i_frame_length),
        .i_end_of_frame (i_end_of_frame),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .o_out_byte     (o_out_byte),
        .o_frame_done   (o_frame_done),
        .o_short_frame  (o_short_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Handshakes are decided at the falling edge; inputs only move at the rising edge.
    always @(negedge i_clk) begin
        in_take   = i_rst_n === 1'b1 && i_in_valid === 1'b1 && o_in_stall === 1'b0;
        out_take  = i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0;
        seen_beat = {o_out_byte, o_frame_done, o_short_frame};
    end

    task automatic report_mismatch(string why);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, why);
    endtask

    task automatic send_item(logic [7:0] pb, logic bv, logic [15:0] fl, logic eof);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_payload_byte <= pb;
        i_byte_valid   <= bv;
        i_frame_length <= fl;
        i_end_of_frame <= eof;
        do @(posedge i_clk); while (!in_take);
        sb.note_item(pb, bv, fl, eof);
        items_sent++;
    endtask

    // Length only counts on the first item; later items carry noise there.
    task automatic send_frame(logic [15:0] declared, int n_items, int skip_pct);
        int k;
        for (k = 0; k < n_items; k++) begin
            send_item(8'($urandom), $urandom_range(0, 99) >= skip_pct,
                      (k == 0) ? declared : 16'($urandom), k == n_items - 1);
        end
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Items that emit nothing may still sit in the block's queue.
    task automatic settle();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [63:0] hb, logic [3:0] hl, logic [63:0] tb,
                                 logic [3:0] tl, t_mode m);
        t_cfg_idx    idx_list[5];
        logic [63:0] vals[5];
        int          k;
        idx_list = '{CFG_HEADER_BYTES, CFG_HEADER_LEN, CFG_TRAILER_BYTES,
                     CFG_TRAILER_LEN, CFG_CHECK_MODE};
        vals     = '{hb, {60'd0, hl}, tb, {60'd0, tl}, {62'd0, m}};
        i_cfg_we <= 1'b1;
        for (k = 0; k < 5; k++) begin
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            sb.write_reg(idx_list[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Result side
    initial begin
        int    stall_len;
        string why;
        i_out_stall = 1'b0;
        forever begin
            stall_len = rx_eager ? 0 : $urandom_range(0, 13);
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_take);
            if (!sb.check_beat(seen_beat, why)) begin
                report_mismatch(why);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || in_take || out_take) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int          n;
        int          kind;
        int          k;
        int          skip_pct;
        int          random_start;
        logic [15:0] declared;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_HEADER_BYTES;
        i_cfg_data     = '0;
        i_payload_byte = '0;
        i_byte_valid   = 1'b0;
        i_frame_length = '0;
        i_end_of_frame = 1'b0;
        i_in_valid     = 1'b0;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: CRC, three-byte header and trailer
        send_item(8'h00, 1'b1, 16'd2, 1'b0);
        send_item(8'hFF, 1'b1, 16'hFFFF, 1'b1);
        // frame with no payload
        send_item(8'h5A, 1'b0, 16'd0, 1'b1);
        // ends before the declared length
        send_item(8'h12, 1'b1, 16'd5, 1'b0);
        send_item(8'h34, 1'b1, 16'd0, 1'b1);
        // bytes past the declared length are dropped
        send_item(8'h01, 1'b1, 16'd1, 1'b0);
        send_item(8'h02, 1'b1, 16'd7, 1'b0);
        send_item(8'h03, 1'b1, 16'd0, 1'b1);
        // declared length beyond the frame room gets clipped
        send_item(8'hC3, 1'b1, 16'hFFFF, 1'b1);
        // empty item in the middle of a frame
        send_item(8'h80, 1'b1, 16'd2, 1'b0);
        send_item(8'h7F, 1'b0, 16'h8000, 1'b0);
        send_item(8'hAA, 1'b1, 16'h0001, 1'b1);

        // oversized header length clamps to eight
        settle();
        apply_setting(64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 64'h0, 4'd8, MODE_SUM16);
        send_item(8'hFF, 1'b1, 16'd3, 1'b0);
        send_item(8'hFF, 1'b1, 16'd3, 1'b0);
        send_item(8'hFF, 1'b1, 16'd3, 1'b1);

        // no header, trailer or check: last item emits nothing, so no done flag
        settle();
        apply_setting(64'h0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, MODE_NONE);
        send_item(8'hA5, 1'b1, 16'd1, 1'b0);
        send_item(8'h5A, 1'b0, 16'd1, 1'b1);
        send_item(8'h3C, 1'b1, 16'd0, 1'b1);

        // byte sum wraps; oversized trailer length clamps
        settle();
        apply_setting({$urandom, $urandom}, 4'd8, {$urandom, $urandom}, 4'hF, MODE_SUM8);
        for (k = 0; k < 4; k++) begin
            send_item(8'hFF, 1'b1, 16'd4, k == 3);
        end

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            settle();
            apply_setting({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                          {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                          t_mode'($urandom_range(0, 3)));
            tx_eager = $urandom_range(0, 3) == 0;
            rx_eager = $urandom_range(0, 3) == 0;
            repeat ($urandom_range(3, 6)) begin
                kind     = $urandom_range(0, 9);
                n        = $urandom_range(1, 6);
                skip_pct = 0;
                declared = 16'(n);
                case (kind)
                    6: declared = 16'(n + $urandom_range(1, 5));
                    7: declared = 16'($urandom_range(0, n - 1));
                    8: skip_pct = 35;
                    9: declared = 16'($urandom);
                    default: ;
                endcase
                send_frame(declared, n, skip_pct);
                if ($urandom_range(0, 7) == 0) begin
                    pause_until_drained();
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sfb_pkg.sv
rtl/sfb_front.sv
rtl/sfb_cmd_fifo.sv
rtl/sfb_back.sv
rtl/serial_frame_builder_top.sv
sim/serial_frame_builder_top_tb.sv
